@@ hw/rtl/rsp_pkg.sv @@
// Package for the RESP stream parser: sizes, codes, payload types.
`default_nettype none
package rsp_pkg;

  localparam int unsigned MAX_DEPTH = 8;
  localparam int unsigned LEN_BITS  = 32;
  localparam int unsigned LVL_W     = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [31:0] TXT_OK   = 32'h0000_4F4B;
  localparam logic [31:0] TXT_NONE = 32'h4E4F_4E45;
  localparam logic [31:0] TXT_PONG = 32'h504F_4E47;

  localparam logic [1:0] SC_OK   = 2'd0;
  localparam logic [1:0] SC_NONE = 2'd1;
  localparam logic [1:0] SC_PONG = 2'd2;

  typedef enum logic [3:0] {
    PH_TYPE,
    PH_SIMPLE_TEXT,
    PH_SIMPLE_LF,
    PH_STR_LEN_FIRST,
    PH_STR_LEN,
    PH_STR_LEN_LF,
    PH_STR_DATA,
    PH_STR_CR,
    PH_STR_LF,
    PH_INT_DATA,
    PH_INT_CR,
    PH_INT_LF,
    PH_ARR_LEN,
    PH_ARR_LF,
    PH_ERR_TEXT,
    PH_ERR_LF
  } phase_e;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_SIMPLE   = 4'd1,
    EV_STR_HDR  = 4'd2,
    EV_STR_BYTE = 4'd3,
    EV_STR_END  = 4'd4,
    EV_INT      = 4'd5,
    EV_ARR_HDR  = 4'd6,
    EV_ERR_BYTE = 4'd7,
    EV_ERR_END  = 4'd8
  } event_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    event_e             event_res;
    logic [7:0]         payload_byte;
    logic signed [63:0] value;
    logic [3:0]         nesting_level;
    logic               message_done;
    logic               message_invalid;
  } out_t;

endpackage
`default_nettype wire

@@ hw/rtl/resp_stream_parser.sv @@
// RESP stream parser top level: input register, single-pass decode, result register.
// Takes one message byte per transfer and reports one result per byte: simple
// words, bulk string headers/bytes/ends, 8-byte big-endian integers, array
// headers and error text, with array nesting tracked up to MAX_DEPTH levels and
// every CR LF checked. A new byte is accepted every clock cycle unless a full,
// unread result register stalls the input; each byte goes through the input
// register and the decode logic into the result register. The rate is set by the
// single-pass decode, where closing nested arrays uses a priority search over
// the per-level "one element left" flags instead of a pop loop. No clearing
// pass is needed after reset.
`default_nettype none
module resp_stream_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rsp_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rsp_pkg::out_t      out_data_o
);
  import rsp_pkg::*;

  // handshake stages
  logic in_valid_q, out_valid_q, adv;
  in_t  in_q;
  out_t out_q, res_c;

  // parser state
  phase_e              phase_q, phase_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic [63:0]         acc_q, acc_d;
  logic [2:0]          bidx_q, bidx_d;
  logic [31:0]         txt_q, txt_d;
  logic [2:0]          tlen_q, tlen_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic                skip_q, skip_d;
  logic [LEN_BITS-1:0] rem_q [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] one_q;

  // decode
  logic [7:0]          b;
  logic                eom, isdig;
  logic [3:0]          dig;
  logic [LEN_BITS+3:0] sum10;
  logic                ovf;
  logic                simple_ok;
  logic [1:0]          simple_code;
  logic                found;
  logic [IDX_W-1:0]    top_idx;
  logic [LEN_BITS-1:0] rem_top;
  event_e              ev_c;
  logic [7:0]          pay_c;
  logic [63:0]         val_c;
  logic                bad_c, fin_c, push_c, done_c, bad_f;

  assign adv         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (adv) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (adv) out_q <= res_c;
  end

  assign b     = in_q.data_byte;
  assign eom   = in_q.end_of_message;
  assign isdig = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dig   = 4'(b - CH_ZERO);
  assign sum10 = {len_q, 3'b000} + {2'b00, len_q, 1'b0} + (LEN_BITS + 4)'(dig);
  assign ovf   = |sum10[LEN_BITS+3:LEN_BITS];

  always_comb begin
    simple_ok   = 1'b1;
    simple_code = SC_OK;
    if (tlen_q == 3'd2 && txt_q == TXT_OK) simple_code = SC_OK;
    else if (tlen_q == 3'd4 && txt_q == TXT_NONE) simple_code = SC_NONE;
    else if (tlen_q == 3'd4 && txt_q == TXT_PONG) simple_code = SC_PONG;
    else simple_ok = 1'b0;
  end

  // innermost open array that still has more than one element to go
  always_comb begin
    found   = 1'b0;
    top_idx = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (LVL_W'(i) < lvl_q && !one_q[i]) begin
        found   = 1'b1;
        top_idx = IDX_W'(i);
      end
    end
  end
  assign rem_top = rem_q[top_idx];

  always_comb begin : decode
    ev_c   = EV_NONE;
    pay_c  = '0;
    val_c  = '0;
    bad_c  = 1'b0;
    fin_c  = 1'b0;
    push_c = 1'b0;
    case (phase_q)
      PH_TYPE: begin
        if (!(b inside {CH_PLUS, CH_DOLLAR, CH_COLON, CH_STAR, CH_MINUS})) bad_c = 1'b1;
      end
      PH_SIMPLE_TEXT: begin
        if (b == CH_CR) bad_c = !simple_ok;
        else if (b == 8'h00 || tlen_q >= 3'd4) bad_c = 1'b1;
      end
      PH_SIMPLE_LF: begin
        if (b != CH_LF) bad_c = 1'b1;
        else begin
          ev_c  = EV_SIMPLE;
          val_c = 64'(len_q);
          fin_c = 1'b1;
        end
      end
      PH_STR_LEN_FIRST, PH_STR_LEN: begin
        if (isdig) bad_c = ovf;
        else if (!(b == CH_CR && phase_q == PH_STR_LEN)) bad_c = 1'b1;
      end
      PH_STR_LEN_LF: begin
        if (b != CH_LF) bad_c = 1'b1;
        else begin
          ev_c  = EV_STR_HDR;
          val_c = 64'(len_q);
        end
      end
      PH_STR_DATA: begin
        ev_c  = EV_STR_BYTE;
        pay_c = b;
      end
      PH_STR_CR, PH_INT_CR: begin
        if (b != CH_CR) bad_c = 1'b1;
      end
      PH_STR_LF: begin
        if (b != CH_LF) bad_c = 1'b1;
        else begin
          ev_c  = EV_STR_END;
          fin_c = 1'b1;
        end
      end
      PH_INT_DATA: ;
      PH_INT_LF: begin
        if (b != CH_LF) bad_c = 1'b1;
        else begin
          ev_c  = EV_INT;
          val_c = acc_q;
          fin_c = 1'b1;
        end
      end
      PH_ARR_LEN: begin
        if (isdig) bad_c = ovf;
        else if (b != CH_CR) bad_c = 1'b1;
      end
      PH_ARR_LF: begin
        if (b != CH_LF) bad_c = 1'b1;
        else begin
          ev_c  = EV_ARR_HDR;
          val_c = 64'(len_q);
          if (len_q == '0) fin_c = 1'b1;
          else if (lvl_q >= LVL_W'(MAX_DEPTH)) bad_c = 1'b1;
          else push_c = 1'b1;
        end
      end
      PH_ERR_TEXT: begin
        if (b == 8'h00) bad_c = 1'b1;
        else if (b != CH_CR) begin
          ev_c  = EV_ERR_BYTE;
          pay_c = b;
        end
      end
      PH_ERR_LF: begin
        if (b != CH_LF) bad_c = 1'b1;
        else begin
          ev_c  = EV_ERR_END;
          fin_c = 1'b1;
        end
      end
      default: bad_c = 1'b1;
    endcase

    done_c = fin_c && !bad_c && !found;
    bad_f  = bad_c || (!done_c && eom);

    res_c = '0;
    if (!skip_q) begin
      if (bad_f) begin
        res_c.message_invalid = 1'b1;
      end else begin
        res_c.event_res     = ev_c;
        res_c.payload_byte  = pay_c;
        res_c.value         = val_c;
        res_c.nesting_level = 4'(lvl_q);
        res_c.message_done  = done_c;
      end
    end
  end

  always_comb begin : next_state
    phase_d = phase_q;
    len_d   = len_q;
    acc_d   = acc_q;
    bidx_d  = bidx_q;
    txt_d   = txt_q;
    tlen_d  = tlen_q;
    lvl_d   = lvl_q;
    skip_d  = skip_q;
    if (!skip_q) begin
      case (phase_q)
        PH_TYPE: begin
          len_d  = '0;
          acc_d  = '0;
          bidx_d = '0;
          txt_d  = '0;
          tlen_d = '0;
          case (b)
            CH_PLUS:   phase_d = PH_SIMPLE_TEXT;
            CH_DOLLAR: phase_d = PH_STR_LEN_FIRST;
            CH_COLON:  phase_d = PH_INT_DATA;
            CH_STAR:   phase_d = PH_ARR_LEN;
            CH_MINUS:  phase_d = PH_ERR_TEXT;
            default:   phase_d = PH_TYPE;
          endcase
        end
        PH_SIMPLE_TEXT: begin
          if (b == CH_CR) begin
            if (simple_ok) begin
              len_d   = LEN_BITS'(simple_code);
              phase_d = PH_SIMPLE_LF;
            end
          end else if (!bad_c) begin
            txt_d  = {txt_q[23:0], b};
            tlen_d = tlen_q + 3'd1;
          end
        end
        PH_STR_LEN_FIRST, PH_STR_LEN: begin
          if (isdig && !ovf) begin
            len_d   = sum10[LEN_BITS-1:0];
            phase_d = PH_STR_LEN;
          end else if (b == CH_CR && phase_q == PH_STR_LEN) begin
            phase_d = PH_STR_LEN_LF;
          end
        end
        PH_STR_LEN_LF: phase_d = (len_q == '0) ? PH_STR_CR : PH_STR_DATA;
        PH_STR_DATA: begin
          len_d = (len_q == '0) ? '0 : len_q - LEN_BITS'(1);
          if (len_d == '0) phase_d = PH_STR_CR;
        end
        PH_STR_CR: phase_d = PH_STR_LF;
        PH_INT_DATA: begin
          acc_d  = {acc_q[55:0], b};
          bidx_d = bidx_q + 3'd1;
          if (bidx_q == 3'd7) phase_d = PH_INT_CR;
        end
        PH_INT_CR: phase_d = PH_INT_LF;
        PH_ARR_LEN: begin
          if (isdig && !ovf) len_d = sum10[LEN_BITS-1:0];
          else if (b == CH_CR) phase_d = PH_ARR_LF;
        end
        PH_ARR_LF: begin
          if (push_c) begin
            lvl_d   = lvl_q + LVL_W'(1);
            len_d   = '0;
            phase_d = PH_TYPE;
          end
        end
        PH_ERR_TEXT: begin
          if (b == CH_CR) phase_d = PH_ERR_LF;
        end
        default: phase_d = phase_q;
      endcase

      if (fin_c && !bad_c) begin
        phase_d = PH_TYPE;
        len_d   = '0;
        lvl_d   = found ? LVL_W'(top_idx) + LVL_W'(1) : '0;
      end

      if (done_c || bad_f) skip_d = 1'b1;
    end

    if ((skip_q || done_c || bad_f) && eom) begin
      phase_d = PH_TYPE;
      len_d   = '0;
      acc_d   = '0;
      bidx_d  = '0;
      txt_d   = '0;
      tlen_d  = '0;
      lvl_d   = '0;
      skip_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      len_q   <= '0;
      acc_q   <= '0;
      bidx_q  <= '0;
      txt_q   <= '0;
      tlen_q  <= '0;
      lvl_q   <= '0;
      skip_q  <= 1'b0;
    end else if (adv) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      bidx_q  <= bidx_d;
      txt_q   <= txt_d;
      tlen_q  <= tlen_d;
      lvl_q   <= lvl_d;
      skip_q  <= skip_d;
    end
  end

  // remaining-count stack; one_q marks entries with a single element left
  always_ff @(posedge clk_i) begin
    if (adv && !skip_q && !bad_f) begin
      if (push_c) begin
        rem_q[lvl_q[IDX_W-1:0]] <= len_q;
        one_q[lvl_q[IDX_W-1:0]] <= (len_q == LEN_BITS'(1));
      end else if (fin_c && found) begin
        rem_q[top_idx] <= rem_top - LEN_BITS'(1);
        one_q[top_idx] <= (rem_top == LEN_BITS'(2));
      end
    end
  end

  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LVL_W'(MAX_DEPTH))
    else $error("stack level beyond max depth");

  a_skip_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !skip_q && (done_c || bad_f) && !eom) |=> skip_q)
    else $error("no skip after finished or malformed message");

  a_done_xor_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.message_done && out_data_o.message_invalid))
    else $error("done and invalid together");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire
